// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
// needs signals clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// File: sv/spr_pkg.sv
// types, codes and helpers for the pattern removal stack
// no dependencies
package spr_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam logic [3:0] MAX_PATTERN = 4'd8;

	localparam logic [7:0] REG_PATTERN_CHARS = 8'd0;
	localparam logic [7:0] REG_PATTERN_LENGTH = 8'd1;

	typedef enum logic [1:0] {
		FN_PUSH = 2'd0,
		FN_READ = 2'd1,
		FN_CLEAR = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [1:0] pad;
		logic overflow;
		logic [CHAR_W-1:0] read_char;
		logic is_empty;
		logic exploded;
		logic [10:0] depth;
	} result_t;

	function automatic logic [3:0] eff_len(input logic [3:0] n);
		logic [3:0] r;
		r = n;
		if (n == 4'd0) begin
			r = 4'd1;
		end else if (n > MAX_PATTERN) begin
			r = MAX_PATTERN;
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] pat_char(input logic [63:0] p, input logic [2:0] i);
		return p[{i, 3'b000} +: CHAR_W];
	endfunction

endpackage

// File: sv/spr_stack_ram.sv
// character stack storage, one write and one registered read per cycle
// uses spr_pkg for the character width
module spr_stack_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = 10
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [spr_pkg::CHAR_W-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [spr_pkg::CHAR_W-1:0] rdata
);

	logic [spr_pkg::CHAR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/stack_pattern_removal.sv
// channel  dir  signals                          transaction
// s        in   s_tvalid s_tready s_tdata s_tuser  one command
// m        out  m_tvalid m_tready m_tdata          one result per command
// cfg      in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// a push that may complete the pattern compares the stored entries below it with the
// pattern, one stored entry compared per cycle through the single ram read port
// a read passes ST_READ for the registered ram read, clear and unused end in ST_IDLE
// arst_n clears the depth, sequencer, output valid and pattern and sets the length to 1
// the stack ram is not cleared, entries at or above the depth are never used
// a new command is taken only once the previous result has gone or is going
// depends on spr_pkg, spr_stack_ram and assert_macros.svh
`include "assert_macros.svh"

module stack_pattern_removal #(
	parameter int unsigned STACK_DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,   // in_char[7:0], read_position[17:8], zero
	input  logic [1:0] s_tuser,    // func[1:0]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,   // depth, exploded, is_empty, read_char, overflow, zero
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CW = (DW > 10) ? DW : 10;

	spr_pkg::state_t state_q, state_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [2:0] k_q, k_d;
	logic [spr_pkg::CHAR_W-1:0] ch_q;
	logic rd_ok_q, rd_ok_d;
	spr_pkg::result_t res_q, res_d;
	logic m_tvalid_q, m_tvalid_d;
	logic [63:0] pat_q;
	logic [3:0] plen_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [spr_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

	logic accept;
	spr_pkg::func_t func;
	logic [spr_pkg::CHAR_W-1:0] in_char;
	logic [9:0] read_position;
	logic [3:0] len;
	logic [2:0] last_idx;
	logic fin, expl, ovf;
	logic [spr_pkg::CHAR_W-1:0] rdc;

	assign func = spr_pkg::func_t'(s_tuser);
	assign in_char = s_tdata[7:0];
	assign read_position = s_tdata[17:8];
	assign len = spr_pkg::eff_len(plen_q);
	assign last_idx = 3'(len - 4'd1);

	assign s_tready = (state_q == spr_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = res_q;
	assign cfg_ready = 1'b1;

	spr_stack_ram #(
		.DEPTH(STACK_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		k_d = k_q;
		rd_ok_d = rd_ok_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		res_d = res_q;
		ram_we = 1'b0;
		ram_waddr = AW'(depth_q);
		ram_wdata = in_char;
		ram_raddr = AW'(depth_q - DW'(1));
		fin = 1'b0;
		expl = 1'b0;
		ovf = 1'b0;
		rdc = '0;
		case (state_q)
			spr_pkg::ST_IDLE: begin
				if (accept) begin
					case (func)
						spr_pkg::FN_PUSH: begin
							if (depth_q == DW'(STACK_DEPTH)) begin
								ovf = 1'b1;
								fin = 1'b1;
							end else if (in_char == spr_pkg::pat_char(pat_q, last_idx) &&
									depth_q >= DW'(last_idx)) begin
								if (last_idx == 3'd0) begin
									expl = 1'b1;
									fin = 1'b1;
								end else begin
									k_d = 3'd1;
									state_d = spr_pkg::ST_CMP;
								end
							end else begin
								ram_we = 1'b1;
								depth_d = depth_q + DW'(1);
								fin = 1'b1;
							end
						end
						spr_pkg::FN_READ: begin
							ram_raddr = AW'(read_position);
							rd_ok_d = CW'(read_position) < CW'(depth_q);
							state_d = spr_pkg::ST_READ;
						end
						spr_pkg::FN_CLEAR: begin
							depth_d = '0;
							fin = 1'b1;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			spr_pkg::ST_CMP: begin
				if (ram_rdata != spr_pkg::pat_char(pat_q, last_idx - k_q)) begin
					ram_we = 1'b1;
					ram_wdata = ch_q;
					depth_d = depth_q + DW'(1);
					fin = 1'b1;
					state_d = spr_pkg::ST_IDLE;
				end else if (k_q == last_idx) begin
					depth_d = depth_q - DW'(last_idx);
					expl = 1'b1;
					fin = 1'b1;
					state_d = spr_pkg::ST_IDLE;
				end else begin
					k_d = k_q + 3'd1;
					ram_raddr = AW'(depth_q - DW'(k_q) - DW'(1));
				end
			end
			spr_pkg::ST_READ: begin
				rdc = rd_ok_q ? ram_rdata : '0;
				fin = 1'b1;
				state_d = spr_pkg::ST_IDLE;
			end
			default: begin
				state_d = spr_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			res_d.pad = '0;
			res_d.overflow = ovf;
			res_d.read_char = rdc;
			res_d.is_empty = (depth_d == '0);
			res_d.exploded = expl;
			res_d.depth = 11'(depth_d);
			m_tvalid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spr_pkg::ST_IDLE;
			depth_q <= '0;
			k_q <= '0;
			m_tvalid_q <= 1'b0;
			pat_q <= '0;
			plen_q <= 4'd1;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			k_q <= k_d;
			m_tvalid_q <= m_tvalid_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == spr_pkg::REG_PATTERN_CHARS) begin
					pat_q <= cfg_data;
				end else if (cfg_index == spr_pkg::REG_PATTERN_LENGTH) begin
					plen_q <= cfg_data[3:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		rd_ok_q <= rd_ok_d;
		if (accept) begin
			ch_q <= in_char;
		end
	end

	`ASSERT_CLK(a_depth_bound, depth_q <= DW'(STACK_DEPTH), "stack depth beyond capacity")
	`ASSERT_CLK(a_cmp_index, (state_q == spr_pkg::ST_CMP) |-> (k_q != 3'd0 && k_q <= last_idx), "compare index out of range")
	`ASSERT_NEVER(a_busy_slot, state_q != spr_pkg::ST_IDLE && m_tvalid_q, "result pending while a command is in progress")

endmodule

// File: sim/stack_pattern_removal_tb.sv
// testbench for stack_pattern_removal: streams push, read, clear and unused commands, predicts
// every result with its own model of the stack and checks each one field by field
// depends on spr_pkg and the stack_pattern_removal rtl
module stack_pattern_removal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH_MAX = 1024;
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned TAIL_CYCLES = 20;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] ch;
		logic [9:0] pos;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	cmd_t pending_cmds[$];
	spr_pkg::result_t expected_results[$];
	cmd_t next_cmd;
	cmd_t taken_cmd;
	spr_pkg::result_t got;
	spr_pkg::result_t want;
	logic s_done = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// model of the stack and the registers
	logic [7:0] stk [DEPTH_MAX];
	int unsigned stk_depth = 0;
	logic [63:0] pat_chars = '0;
	logic [3:0] pat_len = 4'd1;

	stack_pattern_removal #(
		.STACK_DEPTH(DEPTH_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned active_len();
		if (pat_len == 4'd0) begin
			return 1;
		end
		if (pat_len > 4'd8) begin
			return 8;
		end
		return int'(pat_len);
	endfunction

	function automatic logic [7:0] pat_at(input int unsigned i);
		return pat_chars[8*i +: 8];
	endfunction

	function automatic spr_pkg::result_t apply_command(input cmd_t c);
		spr_pkg::result_t r;
		int unsigned n;
		int unsigned k;
		logic hit;
		r = '0;
		case (c.func)
			spr_pkg::FN_PUSH: begin
				if (stk_depth >= DEPTH_MAX) begin
					r.overflow = 1'b1;
				end else begin
					n = active_len();
					hit = (c.ch == pat_at(n - 1)) && (stk_depth >= n - 1);
					for (k = 1; k < n; k++) begin
						if (hit && stk[stk_depth - k] != pat_at(n - 1 - k)) begin
							hit = 1'b0;
						end
					end
					if (hit) begin
						stk_depth = stk_depth - (n - 1);
						r.exploded = 1'b1;
					end else begin
						stk[stk_depth] = c.ch;
						stk_depth++;
					end
				end
			end
			spr_pkg::FN_READ: begin
				if (c.pos < stk_depth) begin
					r.read_char = stk[c.pos];
				end
			end
			spr_pkg::FN_CLEAR: begin
				stk_depth = 0;
			end
			default: begin
			end
		endcase
		r.depth = stk_depth[10:0];
		r.is_empty = (stk_depth == 0);
		return r;
	endfunction

	// driver and ready generation
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_done) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, next_cmd.pos, next_cmd.ch};
					s_tuser <= next_cmd.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// prediction on accepted commands, checking on accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			s_done <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				taken_cmd.func = s_tuser;
				taken_cmd.ch = s_tdata[7:0];
				taken_cmd.pos = s_tdata[17:8];
				expected_results.push_back(apply_command(taken_cmd));
			end
			if (m_tvalid && m_tready) begin
				got = spr_pkg::result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result %h at cycle %0d", m_tdata, cycles);
					end
				end else begin
					want = expected_results.pop_front();
					if (got.depth !== want.depth || got.exploded !== want.exploded
							|| got.is_empty !== want.is_empty
							|| got.read_char !== want.read_char
							|| got.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at cycle %0d: expected depth %0d expl %b empty %b char %h ovf %b",
								cycles, want.depth, want.exploded, want.is_empty,
								want.read_char, want.overflow);
							$display("  got depth %0d expl %b empty %b char %h ovf %b",
								got.depth, got.exploded, got.is_empty, got.read_char,
								got.overflow);
						end
					end
				end
			end
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic queue_cmd(input logic [1:0] func, input logic [7:0] ch, input logic [9:0] pos);
		cmd_t c;
		c.func = func;
		c.ch = ch;
		c.pos = pos;
		pending_cmds.push_back(c);
	endtask

	task automatic push_char(input logic [7:0] ch);
		queue_cmd(spr_pkg::FN_PUSH, ch, 10'($urandom_range(1023)));
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == spr_pkg::REG_PATTERN_CHARS) begin
			pat_chars = val;
		end else if (idx == spr_pkg::REG_PATTERN_LENGTH) begin
			pat_len = val[3:0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] make_pattern(input logic narrow);
		logic [63:0] p;
		int unsigned i;
		for (i = 0; i < 8; i++) begin
			p[8*i +: 8] = narrow ? 8'(8'h41 + $urandom_range(2)) : 8'($urandom_range(255));
		end
		return p;
	endfunction

	task automatic random_phase(input int unsigned items, input int unsigned pause_at);
		int unsigned n;
		int unsigned added;
		int unsigned k;
		int unsigned j;
		int unsigned r;
		logic paused;
		n = active_len();
		added = 0;
		paused = 1'b0;
		while (added < items) begin
			if (pause_at != 0 && added >= pause_at && !paused) begin
				wait_idle();
				paused = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 30) begin
				for (j = 0; j < n; j++) push_char(pat_at(j));
				added += n;
			end else if (r < 50) begin
				// pattern split around a complete one, removed as a chain
				k = (n > 1) ? $urandom_range(n - 1, 1) : 0;
				for (j = 0; j < k; j++) push_char(pat_at(j));
				for (j = 0; j < n; j++) push_char(pat_at(j));
				for (j = k; j < n; j++) push_char(pat_at(j));
				added += 2 * n;
			end else if (r < 62) begin
				push_char(pat_at($urandom_range(n - 1)));
				added++;
			end else if (r < 72) begin
				push_char(8'($urandom_range(255)));
				added++;
			end else if (r < 77) begin
				k = $urandom_range(n - 1);
				for (j = 0; j < k; j++) push_char(pat_at(j));
				push_char(8'($urandom_range(255)));
				added += k + 1;
			end else if (r < 89) begin
				queue_cmd(spr_pkg::FN_READ, 8'($urandom_range(255)),
					10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(31)));
				added++;
			end else if (r < 93) begin
				queue_cmd(spr_pkg::FN_CLEAR, 8'($urandom_range(255)), 10'($urandom_range(1023)));
				added++;
			end else if (r < 95) begin
				queue_cmd(FN_UNUSED, 8'($urandom_range(255)), 10'($urandom_range(1023)));
			end else begin
				push_char(pat_at(n - 1));
				added++;
			end
		end
	endtask

	initial begin
		int unsigned i;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset registers: pattern of one zero character
		queue_cmd(spr_pkg::FN_READ, 8'h00, 10'd0);
		queue_cmd(spr_pkg::FN_READ, 8'hFF, 10'd1023);
		queue_cmd(FN_UNUSED, 8'hFF, 10'd1023);
		push_char(8'h00);
		push_char(8'hFF);
		queue_cmd(spr_pkg::FN_READ, 8'h00, 10'd0);
		queue_cmd(spr_pkg::FN_READ, 8'h00, 10'd1);
		queue_cmd(spr_pkg::FN_CLEAR, 8'h00, 10'd0);
		wait_idle();

		write_reg(spr_pkg::REG_PATTERN_CHARS, 64'hFFFF_FFFF_FF43_4241);
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd3);
		push_char(8'h43);
		push_char(8'h41);
		push_char(8'h41);
		push_char(8'h42);
		push_char(8'h43);
		push_char(8'h42);
		push_char(8'h43);
		queue_cmd(spr_pkg::FN_READ, 8'h00, 10'd0);
		queue_cmd(spr_pkg::FN_CLEAR, 8'h00, 10'd0);
		wait_idle();

		// length zero behaves as one
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd0);
		push_char(8'h41);
		push_char(8'h42);
		wait_idle();

		// length above the maximum behaves as the maximum
		write_reg(spr_pkg::REG_PATTERN_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd15);
		for (i = 0; i < 8; i++) push_char(8'hFF);
		queue_cmd(spr_pkg::FN_CLEAR, 8'h00, 10'd0);
		wait_idle();

		// fill the stack to the top, then push into a full stack
		write_reg(spr_pkg::REG_PATTERN_CHARS, 64'd0);
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd1);
		for (i = 0; i < DEPTH_MAX; i++) push_char(8'($urandom_range(255, 1)));
		push_char(8'h00);
		push_char(8'h55);
		queue_cmd(spr_pkg::FN_READ, 8'h00, 10'd1023);
		queue_cmd(spr_pkg::FN_READ, 8'h00, 10'd0);
		queue_cmd(FN_UNUSED, 8'h00, 10'd0);
		queue_cmd(spr_pkg::FN_CLEAR, 8'h00, 10'd0);
		wait_idle();

		write_reg(spr_pkg::REG_PATTERN_CHARS, make_pattern(1'b1));
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'($urandom_range(5, 2)));
		random_phase(165, 0);
		wait_idle();

		send_idle_pct = 59;
		write_reg(spr_pkg::REG_PATTERN_CHARS, make_pattern(1'b1));
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd8);
		random_phase(165, 80);
		wait_idle();

		send_idle_pct = 0;
		recv_stall_pct = 59;
		write_reg(spr_pkg::REG_PATTERN_CHARS, make_pattern(1'b0));
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd15);
		random_phase(165, 0);
		wait_idle();

		send_idle_pct = 11;
		recv_stall_pct = 11;
		write_reg(spr_pkg::REG_PATTERN_CHARS, make_pattern(1'b1));
		write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'($urandom_range(3, 1)));
		random_phase(165, 0);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
